[sv/prot_pkg.sv]
// ----------------------------------------------------------------------------
// prot_pkg: shared types and constants for the polygon/rectangle overlap test
// Transaction structs, configuration register indexes and decision codes.
// ----------------------------------------------------------------------------
package prot_pkg;

  // Default coordinate width (two's complement, Q16.16 at 32 bits)
  localparam int unsigned CoordBitsDef = 32;

  // Width of the fixed coordinate fields on the ports
  localparam int unsigned FieldBits = 32;

  // Configuration register index width
  localparam int unsigned CfgIdxBits = 4;

  // Configuration register map
  typedef enum logic [CfgIdxBits-1:0] {
    RegRectMinX = 4'd0,
    RegRectMinY = 4'd1,
    RegRectMaxX = 4'd2,
    RegRectMaxY = 4'd3
  } cfg_reg_e;

  // Which test settled the answer
  typedef enum logic [1:0] {
    DecInside   = 2'd0,
    DecRectEdge = 2'd1,
    DecPolyEdge = 2'd2,
    DecNoAxis   = 2'd3
  } decide_e;

  // Polygon kind
  localparam logic ReqTriangle = 1'b0;
  localparam logic ReqQuad     = 1'b1;

  // Input transaction
  typedef struct packed {
    logic                        req_type;
    logic signed [FieldBits-1:0] vert0_x;
    logic signed [FieldBits-1:0] vert0_y;
    logic signed [FieldBits-1:0] vert1_x;
    logic signed [FieldBits-1:0] vert1_y;
    logic signed [FieldBits-1:0] vert2_x;
    logic signed [FieldBits-1:0] vert2_y;
    logic signed [FieldBits-1:0] vert3_x;
    logic signed [FieldBits-1:0] vert3_y;
  } req_item_t;

  // Result transaction
  typedef struct packed {
    logic       overlaps;
    logic [1:0] decided_by;
  } result_item_t;

endpackage

[sv/prot_edge_sep.sv]
// ----------------------------------------------------------------------------
// prot_edge_sep: separating-axis check for one polygon edge
// Projects the four rectangle corners onto the right-hand normal of edge a->b
// with exact products; one register stage sits after the multipliers.
// ----------------------------------------------------------------------------
module prot_edge_sep import prot_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic signed [CoordBits-1:0] a_x_i,
  input  logic signed [CoordBits-1:0] a_y_i,
  input  logic signed [CoordBits-1:0] b_x_i,
  input  logic signed [CoordBits-1:0] b_y_i,
  input  logic signed [CoordBits-1:0] min_x_i,
  input  logic signed [CoordBits-1:0] min_y_i,
  input  logic signed [CoordBits-1:0] max_x_i,
  input  logic signed [CoordBits-1:0] max_y_i,
  output logic                        sep_o
);

  localparam int unsigned DiffBits = CoordBits + 1;
  localparam int unsigned ProdBits = 2 * CoordBits + 2;
  localparam int unsigned ProjBits = 2 * CoordBits + 3;

  logic signed [DiffBits-1:0] ax_w, ay_w, bx_w, by_w;
  logic signed [DiffBits-1:0] mnx_w, mny_w, mxx_w, mxy_w;
  logic signed [DiffBits-1:0] ex, ey, dx_min, dx_max, dy_min, dy_max;
  logic signed [ProdBits-1:0] ey_xmin_d, ey_xmax_d, ex_ymin_d, ex_ymax_d;
  logic signed [ProdBits-1:0] ey_xmin_q, ey_xmax_q, ex_ymin_q, ex_ymax_q;
  logic [3:0]                 front;

  // Sign-extend by one bit so differences cannot overflow
  assign ax_w  = {a_x_i[CoordBits-1], a_x_i};
  assign ay_w  = {a_y_i[CoordBits-1], a_y_i};
  assign bx_w  = {b_x_i[CoordBits-1], b_x_i};
  assign by_w  = {b_y_i[CoordBits-1], b_y_i};
  assign mnx_w = {min_x_i[CoordBits-1], min_x_i};
  assign mny_w = {min_y_i[CoordBits-1], min_y_i};
  assign mxx_w = {max_x_i[CoordBits-1], max_x_i};
  assign mxy_w = {max_y_i[CoordBits-1], max_y_i};

  // Edge vector and corner offsets from the edge start
  assign ex     = bx_w - ax_w;
  assign ey     = by_w - ay_w;
  assign dx_min = mnx_w - ax_w;
  assign dx_max = mxx_w - ax_w;
  assign dy_min = mny_w - ay_w;
  assign dy_max = mxy_w - ay_w;

  // Corners share x and y offsets, so four products cover all four corners
  assign ey_xmin_d = ProdBits'(ey) * ProdBits'(dx_min);
  assign ey_xmax_d = ProdBits'(ey) * ProdBits'(dx_max);
  assign ex_ymin_d = ProdBits'(ex) * ProdBits'(dy_min);
  assign ex_ymax_d = ProdBits'(ex) * ProdBits'(dy_max);

  // Hold the products
  always_ff @(posedge clk_i) begin
    ey_xmin_q <= ey_xmin_d;
    ey_xmax_q <= ey_xmax_d;
    ex_ymin_q <= ex_ymin_d;
    ex_ymax_q <= ex_ymax_d;
  end

  // True when p - q is strictly positive
  function automatic logic diff_pos(logic signed [ProdBits-1:0] p,
                                    logic signed [ProdBits-1:0] q);
    logic signed [ProjBits-1:0] d;
    d = ProjBits'(p) - ProjBits'(q);
    return !d[ProjBits-1] && (d != '0);
  endfunction

  // Corners in counter-clockwise order from the minimum corner
  assign front[0] = diff_pos(ey_xmin_q, ex_ymin_q);
  assign front[1] = diff_pos(ey_xmax_q, ex_ymin_q);
  assign front[2] = diff_pos(ey_xmax_q, ex_ymax_q);
  assign front[3] = diff_pos(ey_xmin_q, ex_ymax_q);

  assign sep_o = &front;

endmodule

[sv/polygon_rect_overlap_test_top.sv]
// ----------------------------------------------------------------------------
// polygon_rect_overlap_test_top: triangle/quad versus rectangle overlap test
// Inside test, then a separating-axis test over rectangle and polygon edges.
// ----------------------------------------------------------------------------
// Each transaction accepted on start gives exactly one result. The result is
// shown on result_o with result_valid_o high for one cycle. Three registers
// carry each transaction to its result: the input register, loaded at the
// accepting edge, a register after the edge multipliers, and the result
// register. busy stays low, so a new transaction can be started in every
// cycle and results stream out at the same rate; the receiver must take each
// result in the cycle it appears. The user must write the rectangle through
// the configuration port only while no transaction is in flight; the block
// itself does not enforce this.
module polygon_rect_overlap_test_top import prot_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  req_item_t             req_i,
  // results
  output logic                  result_valid_o,
  output result_item_t          result_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [FieldBits-1:0]  cfg_data_i
);

  typedef logic signed [CoordBits-1:0] coord_t;

  logic [FieldBits-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
  coord_t               mnx, mny, mxx, mxy;

  logic      in_valid_q;
  req_item_t in_q;
  coord_t    vx [4];
  coord_t    vy [4];
  coord_t    end_x [4];
  coord_t    end_y [4];
  logic [3:0] vert_used;
  logic [3:0] vert_inside;
  logic [3:0] rect_front [4];
  logic [3:0] rect_sep;

  logic mid_valid_q, mid_inside_q, mid_rect_sep_q, mid_quad_q;
  logic [3:0] poly_sep;
  logic       poly_sep_any;

  logic         result_valid_q;
  result_item_t result_d, result_q;

  // Never stalls
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Hold the rectangle bounds; writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      min_y_q <= '0;
      max_x_q <= '0;
      max_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegRectMinX: min_x_q <= cfg_data_i;
        RegRectMinY: min_y_q <= cfg_data_i;
        RegRectMaxX: max_x_q <= cfg_data_i;
        RegRectMaxY: max_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Take the low CoordBits bits, zero-extending when wider than the field
  assign mnx = coord_t'(CoordBits'(min_x_q));
  assign mny = coord_t'(CoordBits'(min_y_q));
  assign mxx = coord_t'(CoordBits'(max_x_q));
  assign mxy = coord_t'(CoordBits'(max_y_q));

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= req_i;
    end
  end

  assign vx[0] = coord_t'(CoordBits'(unsigned'(in_q.vert0_x)));
  assign vy[0] = coord_t'(CoordBits'(unsigned'(in_q.vert0_y)));
  assign vx[1] = coord_t'(CoordBits'(unsigned'(in_q.vert1_x)));
  assign vy[1] = coord_t'(CoordBits'(unsigned'(in_q.vert1_y)));
  assign vx[2] = coord_t'(CoordBits'(unsigned'(in_q.vert2_x)));
  assign vy[2] = coord_t'(CoordBits'(unsigned'(in_q.vert2_y)));
  assign vx[3] = coord_t'(CoordBits'(unsigned'(in_q.vert3_x)));
  assign vy[3] = coord_t'(CoordBits'(unsigned'(in_q.vert3_y)));

  // Vertex 3 takes part only for quads
  assign vert_used = {in_q.req_type == ReqQuad, 3'b111};

  // Inside test and rectangle edge axes; rectangle edges are axis-aligned,
  // so each projection sign reduces to a pair of compares
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vert_inside[i] = vert_used[i] && (vx[i] >= mnx) && (vx[i] <= mxx) &&
                       (vy[i] >= mny) && (vy[i] <= mxy);
      // bottom edge, min corner towards max x
      rect_front[0][i] = !vert_used[i] || ((mxx > mnx) && (vy[i] < mny)) ||
                         ((mxx < mnx) && (vy[i] > mny));
      // right edge
      rect_front[1][i] = !vert_used[i] || ((mxy > mny) && (vx[i] > mxx)) ||
                         ((mxy < mny) && (vx[i] < mxx));
      // top edge
      rect_front[2][i] = !vert_used[i] || ((mnx > mxx) && (vy[i] < mxy)) ||
                         ((mnx < mxx) && (vy[i] > mxy));
      // left edge
      rect_front[3][i] = !vert_used[i] || ((mny > mxy) && (vx[i] > mnx)) ||
                         ((mny < mxy) && (vx[i] < mnx));
    end
    for (int e = 0; e < 4; e++) begin
      rect_sep[e] = &rect_front[e];
    end
  end

  // Polygon edge end points; a triangle closes from vertex 2 to vertex 0
  always_comb begin
    end_x[0] = vx[1];
    end_y[0] = vy[1];
    end_x[1] = vx[2];
    end_y[1] = vy[2];
    end_x[2] = (in_q.req_type == ReqQuad) ? vx[3] : vx[0];
    end_y[2] = (in_q.req_type == ReqQuad) ? vy[3] : vy[0];
    end_x[3] = vx[0];
    end_y[3] = vy[0];
  end

  // One projection unit per polygon edge
  for (genvar g = 0; g < 4; g++) begin : g_edge
    prot_edge_sep #(
      .CoordBits(CoordBits)
    ) u_edge_sep (
      .clk_i  (clk_i),
      .a_x_i  (vx[g]),
      .a_y_i  (vy[g]),
      .b_x_i  (end_x[g]),
      .b_y_i  (end_y[g]),
      .min_x_i(mnx),
      .min_y_i(mny),
      .max_x_i(mxx),
      .max_y_i(mxy),
      .sep_o  (poly_sep[g])
    );
  end

  // Middle stage, alongside the edge products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_inside_q   <= |vert_inside;
    mid_rect_sep_q <= |rect_sep;
    mid_quad_q     <= in_q.req_type == ReqQuad;
  end

  // The fourth polygon edge exists only for quads
  assign poly_sep_any = |poly_sep[2:0] || (poly_sep[3] && mid_quad_q);

  // Decide in test order
  always_comb begin
    priority if (mid_inside_q) begin
      result_d.overlaps   = 1'b1;
      result_d.decided_by = DecInside;
    end else if (mid_rect_sep_q) begin
      result_d.overlaps   = 1'b0;
      result_d.decided_by = DecRectEdge;
    end else if (poly_sep_any) begin
      result_d.overlaps   = 1'b0;
      result_d.decided_by = DecPolyEdge;
    end else begin
      result_d.overlaps   = 1'b1;
      result_d.decided_by = DecNoAxis;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // Every accepted transaction comes out as a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##2 result_valid_o)
    else $error("result missing three cycles after start");

  // No result without a matching accepted transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 3))
    else $error("result without a matching start");

  // Separation and decision code agree
  a_code_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.overlaps ==
      ((result_o.decided_by == DecInside) || (result_o.decided_by == DecNoAxis))))
    else $error("overlap flag disagrees with decision code");

endmodule
